### sv/pce_pkg.sv
// Shared types and constants for the punctured convolutional encoder.
// No dependencies; the design modules import this package.
package pce_pkg;

   localparam int MaxConstraint = 9;
   localparam int MaxGenerators = 4;
   localparam int MaxPeriod     = 32;

   localparam int GenWidth    = 9;
   localparam int CountWidth  = 3;
   localparam int KWidth      = 4;
   localparam int MaskWidth   = 32;
   localparam int PeriodWidth = 6;
   localparam int StateWidth  = 8;
   localparam int PosWidth    = 5;
   localparam int GenSelWidth = 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 32;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_GENERATOR_0       = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_GENERATOR_1       = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_GENERATOR_2       = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_GENERATOR_3       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_GENERATOR_COUNT   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_CONSTRAINT_LENGTH = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_PUNCTURE_MASK     = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_PUNCTURE_PERIOD   = 3'd7;

   // reset values
   localparam logic [GenWidth-1:0]    RST_GENERATOR_0 = 9'o171;
   localparam logic [GenWidth-1:0]    RST_GENERATOR_1 = 9'o133;
   localparam logic [GenWidth-1:0]    RST_GENERATOR_2 = 9'd0;
   localparam logic [GenWidth-1:0]    RST_GENERATOR_3 = 9'd0;
   localparam logic [CountWidth-1:0]  RST_GEN_COUNT   = 3'd2;
   localparam logic [KWidth-1:0]      RST_CONSTRAINT  = 4'd7;
   localparam logic [MaskWidth-1:0]   RST_MASK        = 32'd1;
   localparam logic [PeriodWidth-1:0] RST_PERIOD      = 6'd1;

   typedef struct packed {
      logic [MaxGenerators-1:0][GenWidth-1:0] generator;
      logic [CountWidth-1:0]                  generator_count;
      logic [KWidth-1:0]                      constraint_length;
      logic [MaskWidth-1:0]                   puncture_mask;
      logic [PeriodWidth-1:0]                 puncture_period;
   } cfg_type;

   typedef struct packed {
      logic                  code_bit;
      logic                  keep;
      logic                  step_last;   // last generator of this step
      logic [PosWidth-1:0]   pos_next;
      logic [StateWidth-1:0] state_next;
      logic [KWidth-1:0]     k_minus1;
   } coder_out_type;

   typedef struct packed {
      logic code_bit;
      logic bit_kept;
      logic run_last;
   } rsp_type;

endpackage

### sv/pce_req_if.sv
// Input channel of the punctured convolutional encoder: one data bit per item.
// Standalone interface; no package needed.
interface pce_req_if;
   logic valid;
   logic ready;
   logic data_bit;
   logic end_of_message;

   modport source (output valid, data_bit, end_of_message, input ready);
   modport sink   (input valid, data_bit, end_of_message, output ready);
endinterface

### sv/pce_rsp_if.sv
// Result channel of the punctured convolutional encoder: one coded bit per item.
// Standalone interface; no package needed.
interface pce_rsp_if;
   logic valid;
   logic ready;
   logic code_bit;
   logic bit_kept;
   logic run_last;

   modport source (output valid, code_bit, bit_kept, run_last, input ready);
   modport sink   (input valid, code_bit, bit_kept, run_last, output ready);
endinterface

### sv/pce_cfg_regs.sv
// Configuration register file of the punctured convolutional encoder.
// Depends on pce_pkg.
module pce_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [pce_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [pce_pkg::CsrDataWidth-1:0]    csr_write_data,
   output pce_pkg::cfg_type                    cfg
);
   import pce_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.generator[0]      <= RST_GENERATOR_0;
         cfg_ff.generator[1]      <= RST_GENERATOR_1;
         cfg_ff.generator[2]      <= RST_GENERATOR_2;
         cfg_ff.generator[3]      <= RST_GENERATOR_3;
         cfg_ff.generator_count   <= RST_GEN_COUNT;
         cfg_ff.constraint_length <= RST_CONSTRAINT;
         cfg_ff.puncture_mask     <= RST_MASK;
         cfg_ff.puncture_period   <= RST_PERIOD;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GENERATOR_0:       cfg_ff.generator[0] <= csr_write_data[GenWidth-1:0];
            CSR_GENERATOR_1:       cfg_ff.generator[1] <= csr_write_data[GenWidth-1:0];
            CSR_GENERATOR_2:       cfg_ff.generator[2] <= csr_write_data[GenWidth-1:0];
            CSR_GENERATOR_3:       cfg_ff.generator[3] <= csr_write_data[GenWidth-1:0];
            CSR_GENERATOR_COUNT:   cfg_ff.generator_count <= csr_write_data[CountWidth-1:0];
            CSR_CONSTRAINT_LENGTH: cfg_ff.constraint_length <= csr_write_data[KWidth-1:0];
            CSR_PUNCTURE_MASK:     cfg_ff.puncture_mask <= csr_write_data[MaskWidth-1:0];
            CSR_PUNCTURE_PERIOD:   cfg_ff.puncture_period <= csr_write_data[PeriodWidth-1:0];
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

### sv/pce_coder.sv
// One coded bit: generator parity over the tap window plus the puncture lookup.
// Depends on pce_pkg. Purely combinational.
module pce_coder (
   input  pce_pkg::cfg_type                       cfg,
   input  logic [pce_pkg::StateWidth-1:0]         shift_state,
   input  logic [pce_pkg::PosWidth-1:0]           pattern_position,
   input  logic [pce_pkg::GenSelWidth-1:0]        gen_sel,
   input  logic                                   in_bit,
   output pce_pkg::coder_out_type                 co
);
   import pce_pkg::*;

   logic [KWidth-1:0]      k_eff;
   logic [CountWidth-1:0]  n_eff;
   logic [PeriodWidth-1:0] period_eff;
   logic [StateWidth-1:0]  smask;
   logic [GenWidth-1:0]    window;
   logic [PosWidth-1:0]    pos_eff;
   logic [PeriodWidth-1:0] pos_inc;

   always_comb begin
      // out-of-range settings clamp
      if (cfg.constraint_length < KWidth'(2))
         k_eff = KWidth'(2);
      else if (cfg.constraint_length > KWidth'(MaxConstraint))
         k_eff = KWidth'(MaxConstraint);
      else
         k_eff = cfg.constraint_length;

      if (cfg.generator_count == '0)
         n_eff = CountWidth'(1);
      else if (cfg.generator_count > CountWidth'(MaxGenerators))
         n_eff = CountWidth'(MaxGenerators);
      else
         n_eff = cfg.generator_count;

      if (cfg.puncture_period == '0)
         period_eff = PeriodWidth'(1);
      else if (cfg.puncture_period > PeriodWidth'(MaxPeriod))
         period_eff = PeriodWidth'(MaxPeriod);
      else
         period_eff = cfg.puncture_period;

      smask  = StateWidth'((GenWidth'(1) << (k_eff - KWidth'(1))) - GenWidth'(1));
      window = {shift_state & smask, in_bit};

      pos_eff = ({1'b0, pattern_position} >= period_eff) ? '0 : pattern_position;
      pos_inc = {1'b0, pos_eff} + PeriodWidth'(1);

      co.code_bit   = ^(cfg.generator[gen_sel] & window);
      co.keep       = cfg.puncture_mask[pos_eff];
      co.pos_next   = (pos_inc >= period_eff) ? '0 : pos_inc[PosWidth-1:0];
      co.state_next = window[StateWidth-1:0] & smask;
      co.step_last  = (CountWidth'(gen_sel) + CountWidth'(1)) == n_eff;
      co.k_minus1   = k_eff - KWidth'(1);
   end
endmodule

### sv/pce_rsp_stage.sv
// Result register of the punctured convolutional encoder, drives the result channel.
// Depends on pce_pkg and pce_rsp_if.
module pce_rsp_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  pce_pkg::rsp_type    load_data,
   output logic                free,
   pce_rsp_if.source           rsp_ch
);
   import pce_pkg::*;

   logic    vld_ff;
   logic    vld_in;
   rsp_type data_ff;

   assign free   = !vld_ff || rsp_ch.ready;
   assign vld_in = load || (vld_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_ch.valid    = vld_ff;
   assign rsp_ch.code_bit = data_ff.code_bit;
   assign rsp_ch.bit_kept = data_ff.bit_kept;
   assign rsp_ch.run_last = data_ff.run_last;
endmodule

### sv/punctured_convolutional_encoder_top.sv
// Punctured convolutional encoder, top level; depends on pce_pkg, the channel
// interfaces, pce_cfg_regs, pce_coder and pce_rsp_stage.
// A kept bit is registered in the result stage and valid in the next cycle; in a last item
// each kept bit is held until the next one or the closing cycle, which marks the final result.
// Throughput: one coded bit per cycle while the result channel does not stall. Reset clears
// state and control, registers to defaults.
module punctured_convolutional_encoder_top (
   input  logic                                clock,
   input  logic                                reset,
   pce_req_if.sink                             req_ch,
   pce_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [pce_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [pce_pkg::CsrDataWidth-1:0]    csr_write_data
);
   import pce_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ENC   = 2'd1;
   localparam logic [1:0] PH_FLUSH = 2'd2;

   cfg_type       cfg;
   coder_out_type co;
   rsp_type       load_data;
   logic          load;
   logic          out_free;

   logic [1:0]             phase_ff, phase_in;
   logic                   data_ff, data_in;
   logic                   last_ff, last_in;
   logic [GenSelWidth-1:0] gen_sel_ff, gen_sel_in;
   logic [KWidth-1:0]      step_ff, step_in;
   logic [StateWidth-1:0]  shift_ff, shift_in;
   logic [PosWidth-1:0]    pos_ff, pos_in;
   logic                   hold_vld_ff, hold_vld_in;
   logic                   hold_bit_ff, hold_bit_in;

   logic adv, enc_fire, flush_fire, item_done, accept, in_bit;

   pce_cfg_regs u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // tail steps feed zeros
   assign in_bit = (step_ff == '0) ? data_ff : 1'b0;

   pce_coder u_coder (
      .cfg              (cfg),
      .shift_state      (shift_ff),
      .pattern_position (pos_ff),
      .gen_sel          (gen_sel_ff),
      .in_bit           (in_bit),
      .co               (co)
   );

   pce_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (load_data),
      .free      (out_free),
      .rsp_ch    (rsp_ch)
   );

   assign adv        = (phase_ff != PH_IDLE) && out_free;
   assign enc_fire   = adv && (phase_ff == PH_ENC);
   assign flush_fire = adv && (phase_ff == PH_FLUSH);
   assign item_done  = (enc_fire && co.step_last && !last_ff) || flush_fire;
   assign req_ch.ready = (phase_ff == PH_IDLE) || item_done;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      phase_in    = phase_ff;
      data_in     = data_ff;
      last_in     = last_ff;
      gen_sel_in  = gen_sel_ff;
      step_in     = step_ff;
      shift_in    = shift_ff;
      pos_in      = pos_ff;
      hold_vld_in = hold_vld_ff;
      hold_bit_in = hold_bit_ff;
      load        = 1'b0;
      load_data   = '{code_bit: co.code_bit, bit_kept: 1'b1, run_last: 1'b0};

      if (enc_fire) begin
         pos_in = co.pos_next;
         if (co.keep) begin
            if (!last_ff) begin
               load = 1'b1;
            end else begin
               // last item: hold one kept bit back so the final one can be marked
               if (hold_vld_ff) begin
                  load      = 1'b1;
                  load_data = '{code_bit: hold_bit_ff, bit_kept: 1'b1, run_last: 1'b0};
               end
               hold_vld_in = 1'b1;
               hold_bit_in = co.code_bit;
            end
         end
         if (co.step_last) begin
            gen_sel_in = '0;
            shift_in   = co.state_next;
            if (last_ff && (step_ff < co.k_minus1)) begin
               step_in = step_ff + KWidth'(1);
            end else if (last_ff) begin
               phase_in = PH_FLUSH;
            end else begin
               phase_in = PH_IDLE;
            end
         end else begin
            gen_sel_in = gen_sel_ff + GenSelWidth'(1);
         end
      end

      if (flush_fire) begin
         // closing item: carries the held final bit, or is a filler when nothing of the final run survived
         load        = 1'b1;
         load_data   = '{code_bit: hold_vld_ff & hold_bit_ff, bit_kept: hold_vld_ff,
                         run_last: 1'b1};
         hold_vld_in = 1'b0;
         shift_in    = '0;
         pos_in      = '0;
         phase_in    = PH_IDLE;
      end

      if (accept) begin
         phase_in   = PH_ENC;
         data_in    = req_ch.data_bit;
         last_in    = req_ch.end_of_message;
         gen_sel_in = '0;
         step_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         gen_sel_ff  <= '0;
         step_ff     <= '0;
         shift_ff    <= '0;
         pos_ff      <= '0;
         hold_vld_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         gen_sel_ff  <= gen_sel_in;
         step_ff     <= step_in;
         shift_ff    <= shift_in;
         pos_ff      <= pos_in;
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      last_ff     <= last_in;
      hold_bit_ff <= hold_bit_in;
   end

   a_hold_only_in_last: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> (last_ff && (phase_ff != PH_IDLE)))
      else $error("held bit outside a last item");

   a_accept_when_done: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff != PH_IDLE)) |-> item_done)
      else $error("item taken while the previous one is still encoding");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      flush_fire |=> ((pos_ff == '0) && (shift_ff == '0) && !hold_vld_ff))
      else $error("state not cleared after message end");

   a_flush_emits: assert property (@(posedge clock) disable iff (reset)
      flush_fire |-> (load && load_data.run_last))
      else $error("message end produced no final item");
endmodule
